FILE: rtl/core/pecso_pkg.sv
`default_nettype none
package pecso_pkg;

  localparam int unsigned HighDepth = 32;
  localparam int unsigned LowDepth  = 512;

  localparam int unsigned HighPtrW = $clog2(HighDepth);
  localparam int unsigned HighCntW = $clog2(HighDepth + 1);
  localparam int unsigned LowPtrW  = $clog2(LowDepth);
  localparam int unsigned LowCntW  = $clog2(LowDepth + 1);

  localparam int unsigned CodeW     = 16;
  localparam int unsigned LevelW    = 9;
  localparam int unsigned LowFreeW  = 10;

  // high pushes must lie above the printable range
  localparam logic [CodeW-1:0] AsciiTop = 16'd127;

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_PUSH_LOW   = 2'd1,
    ACT_PUSH_BACK  = 2'd2,
    ACT_PUSH_FRONT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_TICK_ODD   = 3'd0,
    OP_TICK_EVEN  = 3'd1,
    OP_PUSH_LOW   = 3'd2,
    OP_PUSH_BACK  = 3'd3,
    OP_PUSH_FRONT = 3'd4
  } op_e;

  typedef struct packed {
    action_e          action;
    logic [CodeW-1:0] code;
    logic             tick_odd;
  } item_t;

  typedef struct packed {
    logic [CodeW-1:0]    pin_code;
    logic                strobe_level;
    status_e             status;
    logic [LowFreeW-1:0] low_free;
    logic                notify;
  } result_t;

  typedef struct packed {
    op_e              op;
    logic             range_ok;
    logic [CodeW-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [CodeW-1:0]  code_mask;
    logic              test_mode;
    logic [LevelW-1:0] notify_level;
    logic              test_clr;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/pecso_ram.sv
`default_nettype none
module pecso_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/pecso_front.sv
`default_nettype none
module pecso_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire pecso_pkg::item_t  item_i,
  input  wire logic [pecso_pkg::CodeW-1:0] code_mask_i,
  output logic                   cmd_valid_o,
  output pecso_pkg::cmd_t        cmd_o,
  input  wire logic              cmd_take_i
);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  pecso_pkg::cmd_t  entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  pecso_pkg::cmd_t  cls;
  logic             accept;
  logic             take;

  // classify: decode the action and check the code range up front
  always_comb begin
    cls.code     = item_i.code;
    cls.range_ok = 1'b1;
    cls.op       = pecso_pkg::OP_TICK_EVEN;
    unique case (item_i.action)
      pecso_pkg::ACT_TICK: begin
        cls.op = item_i.tick_odd ? pecso_pkg::OP_TICK_ODD : pecso_pkg::OP_TICK_EVEN;
      end
      pecso_pkg::ACT_PUSH_LOW: begin
        cls.op       = pecso_pkg::OP_PUSH_LOW;
        cls.range_ok = (item_i.code != '0) && (item_i.code <= code_mask_i);
      end
      pecso_pkg::ACT_PUSH_BACK: begin
        cls.op       = pecso_pkg::OP_PUSH_BACK;
        cls.range_ok = (item_i.code > pecso_pkg::AsciiTop) && (item_i.code <= code_mask_i);
      end
      pecso_pkg::ACT_PUSH_FRONT: begin
        cls.op       = pecso_pkg::OP_PUSH_FRONT;
        cls.range_ok = (item_i.code > pecso_pkg::AsciiTop) && (item_i.code <= code_mask_i);
      end
      default: begin
        cls.op = pecso_pkg::OP_TICK_EVEN;
      end
    endcase
  end

  assign busy        = (cnt_q == QCntW'(QueueDepth));
  assign accept      = start && !busy;
  assign cmd_valid_o = (cnt_q != '0);
  assign take        = cmd_take_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (take) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (accept && !take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (take && !accept) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pecso_back.sv
`default_nettype none
module pecso_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire pecso_pkg::cmd_t   cmd_i,
  output logic                   cmd_take_o,
  input  wire pecso_pkg::cfg_t   cfg_i,
  output logic                   res_valid_o,
  output pecso_pkg::result_t     res_o
);

  localparam int unsigned HighD  = pecso_pkg::HighDepth;
  localparam int unsigned LowD   = pecso_pkg::LowDepth;
  localparam int unsigned HPtrW  = pecso_pkg::HighPtrW;
  localparam int unsigned HCntW  = pecso_pkg::HighCntW;
  localparam int unsigned LPtrW  = pecso_pkg::LowPtrW;
  localparam int unsigned LCntW  = pecso_pkg::LowCntW;
  localparam int unsigned CodeW  = pecso_pkg::CodeW;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StPopHigh = 2'd1;
  localparam logic [1:0] StPopLow  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [HPtrW-1:0] h_ptr_q, h_ptr_d;
  logic [HCntW-1:0] h_cnt_q, h_cnt_d;
  logic [LPtrW-1:0] l_ptr_q, l_ptr_d;
  logic [LCntW-1:0] l_cnt_q, l_cnt_d;
  logic [CodeW-1:0] pins_q, pins_d;
  logic             strobe_q, strobe_d;
  logic [CodeW-1:0] test_cnt_q, test_cnt_d;
  logic             notify_q, notify_d;
  logic             res_valid_q, res_valid_d;
  pecso_pkg::result_t res_q, res_d;

  logic             h_we, h_re, l_we, l_re;
  logic [HPtrW-1:0] h_waddr;
  logic [LPtrW-1:0] l_waddr;
  logic [CodeW-1:0] h_rdata, l_rdata;
  logic [HPtrW:0]   h_sum;
  logic [LPtrW:0]   l_sum;
  logic [HPtrW-1:0] h_tail, h_ptr_dec, h_ptr_inc;
  logic [LPtrW-1:0] l_tail, l_ptr_inc;
  logic             h_full, l_full;
  logic [15:0]      low_free_now;
  logic             notify_now;
  logic             emit;
  pecso_pkg::status_e stat;

  // tail address = read pointer plus count, wrapped once
  assign h_sum  = (HPtrW + 1)'(h_ptr_q) + (HPtrW + 1)'(h_cnt_q);
  assign h_tail = (h_sum >= (HPtrW + 1)'(HighD)) ? HPtrW'(h_sum - (HPtrW + 1)'(HighD))
                                                  : HPtrW'(h_sum);
  assign l_sum  = (LPtrW + 1)'(l_ptr_q) + (LPtrW + 1)'(l_cnt_q);
  assign l_tail = (l_sum >= (LPtrW + 1)'(LowD)) ? LPtrW'(l_sum - (LPtrW + 1)'(LowD))
                                                : LPtrW'(l_sum);
  assign h_ptr_dec = (h_ptr_q == '0) ? HPtrW'(HighD - 1) : h_ptr_q - 1'b1;
  assign h_ptr_inc = (h_ptr_q == HPtrW'(HighD - 1)) ? '0 : h_ptr_q + 1'b1;
  assign l_ptr_inc = (l_ptr_q == LPtrW'(LowD - 1)) ? '0 : l_ptr_q + 1'b1;
  assign h_full    = (h_cnt_q == HCntW'(HighD));
  assign l_full    = (l_cnt_q == LCntW'(LowD));

  // free slots counted before any pop
  assign low_free_now = 16'(LowD) - 16'(l_cnt_q);
  assign notify_now   = (cfg_i.notify_level != '0) && (low_free_now == 16'(cfg_i.notify_level));

  always_comb begin
    state_d     = state_q;
    h_ptr_d     = h_ptr_q;
    h_cnt_d     = h_cnt_q;
    l_ptr_d     = l_ptr_q;
    l_cnt_d     = l_cnt_q;
    pins_d      = pins_q;
    strobe_d    = strobe_q;
    test_cnt_d  = test_cnt_q;
    notify_d    = notify_q;
    h_we        = 1'b0;
    h_re        = 1'b0;
    l_we        = 1'b0;
    l_re        = 1'b0;
    h_waddr     = h_tail;
    l_waddr     = l_tail;
    cmd_take_o  = 1'b0;
    emit        = 1'b0;
    stat        = pecso_pkg::STAT_OK;

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          notify_d   = 1'b0;
          unique case (cmd_i.op)
            pecso_pkg::OP_PUSH_LOW: begin
              emit = 1'b1;
              if (!cmd_i.range_ok) begin
                stat = pecso_pkg::STAT_RANGE;
              end else if (l_full) begin
                stat = pecso_pkg::STAT_FULL;
              end else begin
                l_we    = 1'b1;
                l_cnt_d = l_cnt_q + 1'b1;
              end
            end
            pecso_pkg::OP_PUSH_BACK, pecso_pkg::OP_PUSH_FRONT: begin
              emit = 1'b1;
              if (!cmd_i.range_ok) begin
                stat = pecso_pkg::STAT_RANGE;
              end else if (h_full) begin
                stat = pecso_pkg::STAT_FULL;
              end else begin
                h_we    = 1'b1;
                h_cnt_d = h_cnt_q + 1'b1;
                // front insert into a non-empty queue moves the head back
                if (cmd_i.op == pecso_pkg::OP_PUSH_FRONT && h_cnt_q != '0) begin
                  h_waddr = h_ptr_dec;
                  h_ptr_d = h_ptr_dec;
                end
              end
            end
            pecso_pkg::OP_TICK_ODD: begin
              emit = 1'b1;
              if (strobe_q) begin
                strobe_d = 1'b0;
                pins_d   = '0;
              end
            end
            pecso_pkg::OP_TICK_EVEN: begin
              notify_d = notify_now;
              if (cfg_i.test_mode) begin
                emit       = 1'b1;
                pins_d     = test_cnt_q & cfg_i.code_mask;
                strobe_d   = 1'b1;
                test_cnt_d = (test_cnt_q < cfg_i.code_mask) ? test_cnt_q + 1'b1 : '0;
              end else if (h_cnt_q != '0) begin
                h_re    = 1'b1;
                state_d = StPopHigh;
              end else if (l_cnt_q != '0) begin
                l_re    = 1'b1;
                state_d = StPopLow;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      StPopHigh: begin
        emit     = 1'b1;
        pins_d   = h_rdata & cfg_i.code_mask;
        strobe_d = 1'b1;
        h_ptr_d  = h_ptr_inc;
        h_cnt_d  = h_cnt_q - 1'b1;
        state_d  = StIdle;
      end
      StPopLow: begin
        emit     = 1'b1;
        pins_d   = l_rdata & cfg_i.code_mask;
        strobe_d = 1'b1;
        l_ptr_d  = l_ptr_inc;
        l_cnt_d  = l_cnt_q - 1'b1;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_i.test_clr) begin
      test_cnt_d = '0;
    end

    res_valid_d = emit;
    res_d       = res_q;
    if (emit) begin
      res_d.pin_code     = pins_d;
      res_d.strobe_level = strobe_d;
      res_d.status       = stat;
      res_d.low_free     = pecso_pkg::LowFreeW'(LowD - l_cnt_d);
      res_d.notify       = notify_d;
    end
  end

  pecso_ram #(
    .Width (CodeW),
    .Depth (HighD)
  ) u_high_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (cmd_i.code),
    .re_i    (h_re),
    .raddr_i (h_ptr_q),
    .rdata_o (h_rdata)
  );

  pecso_ram #(
    .Width (CodeW),
    .Depth (LowD)
  ) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (cmd_i.code),
    .re_i    (l_re),
    .raddr_i (l_ptr_q),
    .rdata_o (l_rdata)
  );

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      h_ptr_q     <= '0;
      h_cnt_q     <= '0;
      l_ptr_q     <= '0;
      l_cnt_q     <= '0;
      pins_q      <= '0;
      strobe_q    <= 1'b0;
      test_cnt_q  <= '0;
      notify_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_ptr_q     <= h_ptr_d;
      h_cnt_q     <= h_cnt_d;
      l_ptr_q     <= l_ptr_d;
      l_cnt_q     <= l_cnt_d;
      pins_q      <= pins_d;
      strobe_q    <= strobe_d;
      test_cnt_q  <= test_cnt_d;
      notify_q    <= notify_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: rtl/core/priority_event_code_strobe_output_top.sv
// result path: a push, an odd tick or an even tick that pops nothing gives its result strobe
// through the command queue and then the result register once start is taken; an even tick
// that pops a queue also passes through the registered read of the queue memory.
// throughput: one item per cycle into a two-entry command queue, busy rises while it is
// full; the executing side takes a command when idle and holds in a pop state for a pop.
// reset clears all queues, pointers, pins, strobe and test counter; code_bits resets to 8.
`default_nettype none
module priority_event_code_strobe_output_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire pecso_pkg::item_t   item_i,
  output logic                    res_valid_o,
  output pecso_pkg::result_t      res_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam logic [1:0] RegCodeBits    = 2'd0;
  localparam logic [1:0] RegTestMode    = 2'd1;
  localparam logic [1:0] RegNotifyLevel = 2'd2;

  logic [4:0]                     code_bits_q, code_bits_d;
  logic                           test_mode_q, test_mode_d;
  logic [pecso_pkg::LevelW-1:0]   level_q, level_d;
  logic                           test_clr;
  logic                           wr_en;
  logic [1:0]                     reg_idx;
  logic [4:0]                     bits_sat;
  pecso_pkg::cfg_t                cfg;
  logic                           cmd_valid;
  logic                           cmd_take;
  pecso_pkg::cmd_t                cmd;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    code_bits_d = code_bits_q;
    test_mode_d = test_mode_q;
    level_d     = level_q;
    test_clr    = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        RegCodeBits:    code_bits_d = pwdata[4:0];
        RegTestMode: begin
          test_mode_d = pwdata[0];
          test_clr    = pwdata[0];
        end
        RegNotifyLevel: level_d = pwdata[pecso_pkg::LevelW-1:0];
        default:        code_bits_d = code_bits_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegCodeBits:    prdata = {27'd0, code_bits_q};
      RegTestMode:    prdata = {31'd0, test_mode_q};
      RegNotifyLevel: prdata = {23'd0, level_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= 5'd8;
      test_mode_q <= 1'b0;
      level_q     <= '0;
    end else begin
      code_bits_q <= code_bits_d;
      test_mode_q <= test_mode_d;
      level_q     <= level_d;
    end
  end

  // pin count saturated to one through sixteen
  assign bits_sat = (code_bits_q == 5'd0) ? 5'd1 :
                    (code_bits_q > 5'd16) ? 5'd16 : code_bits_q;

  assign cfg.code_mask    = 16'hFFFF >> (5'd16 - bits_sat);
  assign cfg.test_mode    = test_mode_q;
  assign cfg.notify_level = level_q;
  assign cfg.test_clr     = test_clr;

  pecso_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .code_mask_i (cfg.code_mask),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  pecso_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .cfg_i       (cfg),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire
